### hw/rtl/scws_pkg.sv
package scws_pkg;

    // Stream payload layout
    localparam int ROW_BITS      = 4;
    localparam int COL_BITS      = 4;
    localparam int IN_WT_BITS    = 32;
    localparam int S_TDATA_BITS  = 40;   // row, col, weight
    localparam int MASK_BITS     = 16;
    localparam int SCORE_BITS    = 36;
    localparam int M_TDATA_BITS  = 56;   // mask, score, zero pad
    localparam int M_PAD_BITS    = M_TDATA_BITS - MASK_BITS - SCORE_BITS;

    // Config port
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int NC_BITS       = 5;
    localparam logic [NC_BITS-1:0] NODE_COUNT_RESET = 5'd16;

    // Register index (paddr[2])
    localparam logic [0:0] REG_NODE_COUNT = 1'b0;

    // Command codes carried on s_tuser
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Accumulator control from the sequencer
    typedef struct packed {
        logic run_clr;    // zero the running sum
        logic run_add;    // add the weight read last cycle
        logic best_load;  // take running sum and set as best unconditionally
        logic best_cmp;   // take them only when strictly greater
    } acc_ctrl_t;

endpackage

### hw/rtl/scws_acc.sv
module scws_acc #(
    parameter int MAX_NODES   = 16,
    parameter int WEIGHT_BITS = 32,
    parameter int SUM_BITS    = 36
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  scws_pkg::acc_ctrl_t                ctrl,
    input  logic signed [WEIGHT_BITS-1:0]      add_val,
    input  logic [MAX_NODES-1:0]               cur_set,
    output logic [scws_pkg::MASK_BITS-1:0]     best_mask,
    output logic signed [scws_pkg::SCORE_BITS-1:0] best_score
);

    logic signed [SUM_BITS-1:0] run_sum_reg;
    logic signed [SUM_BITS-1:0] best_sum_reg;
    logic [MAX_NODES-1:0]       best_set_reg;
    logic                       take_best;

    // single adder and single compare, shared by every subset
    assign take_best = ctrl.best_load || (ctrl.best_cmp && (run_sum_reg > best_sum_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_sum_reg  <= '0;
            best_sum_reg <= '0;
            best_set_reg <= '0;
        end
        else
        begin
            if (take_best)
            begin
                best_sum_reg <= run_sum_reg;
                best_set_reg <= cur_set;
            end
            if (ctrl.run_clr)
                run_sum_reg <= '0;
            else if (ctrl.run_add)
                run_sum_reg <= run_sum_reg + SUM_BITS'(add_val);
        end
    end

    assign best_mask = scws_pkg::MASK_BITS'(best_set_reg);

    generate
        if (SUM_BITS > scws_pkg::SCORE_BITS)
        begin : g_sat
            localparam logic signed [SUM_BITS-1:0] SAT_HI =
                SUM_BITS'((64'sd1 <<< (scws_pkg::SCORE_BITS - 1)) - 64'sd1);
            localparam logic signed [SUM_BITS-1:0] SAT_LO = -SAT_HI - SUM_BITS'(1);
            always_comb
            begin
                priority if (best_sum_reg > SAT_HI)
                    best_score = scws_pkg::SCORE_BITS'(SAT_HI);
                else if (best_sum_reg < SAT_LO)
                    best_score = scws_pkg::SCORE_BITS'(SAT_LO);
                else
                    best_score = scws_pkg::SCORE_BITS'(best_sum_reg);
            end
        end
        else
        begin : g_ext
            assign best_score = scws_pkg::SCORE_BITS'(best_sum_reg);
        end
    endgenerate

endmodule

### hw/rtl/subset_chain_weight_search_top.sv
// Subset chain weight search.
// Input stream (s_*): one item per command. s_tuser = cmd (write weight / start).
//   A write item stores one signed weight at (row, col) and gives no result.
//   A start item searches all nonempty subsets of nodes 0..n-1 (n = node_count
//   register, clamped to 1..MAX_NODES) and gives one result item.
// Output (m_*): best_mask and best_score of the best subset, saturated if the sum is wider.
// Config (APB): node_count at byte address 0, reset value 16.
// Search: a start item runs one pass over the full chain, then one pass per
//   mask 1..2^n-1; each pass walks the n node bits of the mask (ST_SCAN),
//   adds the last pending weight (ST_DRAIN) and compares with the best
//   (ST_CMP), paced by the single weight-memory read port and the shared
//   add/compare unit. Write items are accepted back to back.
// s_tready is low for the whole search. The result sits in an output register;
//   if the receiver stalls, a finished search waits until the previous result
//   is taken, and new items are accepted as soon as the result is registered.
// Reset: config returns to 16, sequencer idle, no result pending. Weights are
//   not cleared; every weight a search uses must be written first.
module subset_chain_weight_search_top #(
    parameter int MAX_NODES   = 16,
    parameter int WEIGHT_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input items
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [scws_pkg::S_TDATA_BITS-1:0]     s_tdata,   // row[3:0] col[7:4] weight[39:8]
    input  logic                                  s_tuser,   // cmd[0]
    // result items
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [scws_pkg::M_TDATA_BITS-1:0]     m_tdata,   // best_mask[15:0] best_score[51:16]
    // config
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [scws_pkg::CFG_ADDR_BITS-1:0]    paddr,
    input  logic [scws_pkg::CFG_DATA_BITS-1:0]    pwdata,
    output logic [scws_pkg::CFG_DATA_BITS-1:0]    prdata,
    output logic                                  pready
);

    localparam int IW       = $clog2(MAX_NODES);
    localparam int NW       = $clog2(MAX_NODES + 1);
    localparam int DEPTH    = MAX_NODES * MAX_NODES;
    localparam int AW       = $clog2(DEPTH);
    localparam int SUM_BITS = WEIGHT_BITS + $clog2(MAX_NODES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,   // walk node bits of current mask, one per cycle
        ST_DRAIN,  // last pending add
        ST_CMP,    // compare with best, step mask
        ST_DONE    // hand result to output register
    } state_t;

    // ---------------- config register ----------------
    logic [scws_pkg::NC_BITS-1:0] node_count_reg;
    logic                         cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            node_count_reg <= scws_pkg::NODE_COUNT_RESET;
        else if (cfg_wr && (paddr[2:2] == scws_pkg::REG_NODE_COUNT))
            node_count_reg <= pwdata[scws_pkg::NC_BITS-1:0];
    end

    assign prdata = (paddr[2:2] == scws_pkg::REG_NODE_COUNT) ?
                    scws_pkg::CFG_DATA_BITS'(node_count_reg) : '0;

    // ---------------- input fields ----------------
    logic [scws_pkg::ROW_BITS-1:0]         in_row;
    logic [scws_pkg::COL_BITS-1:0]         in_col;
    logic signed [scws_pkg::IN_WT_BITS-1:0] in_weight;
    logic                                  s_fire;
    logic                                  in_rc_ok;

    assign in_row    = s_tdata[3:0];
    assign in_col    = s_tdata[7:4];
    assign in_weight = s_tdata[39:8];
    assign s_fire    = s_tvalid && s_tready;
    assign in_rc_ok  = (32'(in_row) < MAX_NODES) && (32'(in_col) < MAX_NODES);

    // clamp node count to 1..MAX_NODES
    logic [NW-1:0]        n_clamp;
    logic [MAX_NODES-1:0] full_mask;

    always_comb
    begin
        priority if (node_count_reg == '0)
            n_clamp = NW'(1);
        else if (32'(node_count_reg) > MAX_NODES)
            n_clamp = NW'(MAX_NODES);
        else
            n_clamp = NW'(node_count_reg);
    end

    assign full_mask = ~({MAX_NODES{1'b1}} << n_clamp);

    // ---------------- sequencer ----------------
    state_t               state_reg;
    logic [NW-1:0]        n_reg;
    logic [MAX_NODES-1:0] full_reg;
    logic [MAX_NODES-1:0] mask_reg;
    logic                 first_reg;    // pass over the full chain sets the initial best
    logic [IW-1:0]        bit_reg;
    logic [IW-1:0]        prev_reg;
    logic                 prev_vld_reg;
    logic                 add_pend_reg; // memory read issued last cycle must be added
    logic                 m_tvalid_reg;
    logic [scws_pkg::M_TDATA_BITS-1:0] m_tdata_reg;

    logic                 hit;
    logic                 last_bit;
    logic [scws_pkg::MASK_BITS-1:0]         acc_mask;
    logic signed [scws_pkg::SCORE_BITS-1:0] acc_score;

    assign hit      = mask_reg[bit_reg];
    assign last_bit = (NW'(bit_reg) == (n_reg - NW'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            n_reg        <= '0;
            full_reg     <= '0;
            mask_reg     <= '0;
            first_reg    <= 1'b0;
            bit_reg      <= '0;
            prev_reg     <= '0;
            prev_vld_reg <= 1'b0;
            add_pend_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            // ST_DONE reloads the output register itself
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE))
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    add_pend_reg <= 1'b0;
                    if (s_fire && (s_tuser == scws_pkg::CMD_START))
                    begin
                        n_reg        <= n_clamp;
                        full_reg     <= full_mask;
                        mask_reg     <= full_mask;
                        first_reg    <= 1'b1;
                        bit_reg      <= '0;
                        prev_vld_reg <= 1'b0;
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    add_pend_reg <= hit && prev_vld_reg;
                    if (hit)
                    begin
                        prev_reg     <= bit_reg;
                        prev_vld_reg <= 1'b1;
                    end
                    if (last_bit)
                        state_reg <= ST_DRAIN;
                    else
                        bit_reg <= bit_reg + IW'(1);
                end
                ST_DRAIN:
                begin
                    add_pend_reg <= 1'b0;
                    state_reg    <= ST_CMP;
                end
                ST_CMP:
                begin
                    bit_reg      <= '0;
                    prev_vld_reg <= 1'b0;
                    if (first_reg)
                    begin
                        first_reg <= 1'b0;
                        mask_reg  <= MAX_NODES'(1);
                        state_reg <= ST_SCAN;
                    end
                    else if (mask_reg == full_reg)
                        state_reg <= ST_DONE;
                    else
                    begin
                        mask_reg  <= mask_reg + MAX_NODES'(1);
                        state_reg <= ST_SCAN;
                    end
                end
                ST_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {{scws_pkg::M_PAD_BITS{1'b0}}, acc_score, acc_mask};
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- weight memory ----------------
    logic signed [WEIGHT_BITS-1:0] wmem [DEPTH];
    logic signed [WEIGHT_BITS-1:0] rd_data_reg;
    logic [AW-1:0]                 wr_addr;
    logic [AW-1:0]                 rd_addr;
    logic                          wr_en;

    assign wr_en   = s_fire && (s_tuser == scws_pkg::CMD_WRITE) && in_rc_ok;
    assign wr_addr = AW'(IW'(in_row)) * AW'(MAX_NODES) + AW'(IW'(in_col));
    assign rd_addr = AW'(prev_reg) * AW'(MAX_NODES) + AW'(bit_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            wmem[wr_addr] <= WEIGHT_BITS'(in_weight);
        rd_data_reg <= wmem[rd_addr];
    end

    // ---------------- shared add / compare unit ----------------
    scws_pkg::acc_ctrl_t acc_ctrl;

    always_comb
    begin
        acc_ctrl.run_clr   = (state_reg == ST_CMP) ||
                             (s_fire && (s_tuser == scws_pkg::CMD_START));
        acc_ctrl.run_add   = add_pend_reg;
        acc_ctrl.best_load = (state_reg == ST_CMP) && first_reg;
        acc_ctrl.best_cmp  = (state_reg == ST_CMP) && !first_reg;
    end

    scws_acc #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_BITS),
        .SUM_BITS    (SUM_BITS)
    ) u_acc (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (acc_ctrl),
        .add_val    (rd_data_reg),
        .cur_set    (mask_reg),
        .best_mask  (acc_mask),
        .best_score (acc_score)
    );

    // ---------------- assertions ----------------
    a_add_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        add_pend_reg |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("pending add outside subset walk");

    a_start_walks: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && s_tuser == scws_pkg::CMD_START) |=> (state_reg == ST_SCAN && first_reg))
        else $error("start did not begin the full-chain pass");

    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (NW'(bit_reg) < n_reg))
        else $error("node index beyond node count");

    a_done_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && (!m_tvalid_reg || m_tready)) |=>
        (m_tvalid_reg && state_reg == ST_IDLE))
        else $error("finished search did not produce a result");

endmodule
